### rtl/sfr_pkg.sv
package sfr_pkg;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 4;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int QUEUE_DEPTH_DEF     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

endpackage

### rtl/stream_find_and_replace.sv
// Byte stream find-and-replace. Every leftmost, non-overlapping occurrence of
// the pattern (pattern_length bytes, up to MAX_PATTERN) is replaced by the
// replacement (replacement_length bytes, up to MAX_REPLACEMENT); a zero
// pattern length passes bytes through unchanged. The input side takes one
// byte per cycle while the 4-entry command queue has room. The output side
// sends one result per cycle while out_stall is low, so a byte that completes a
// match sends replacement_length results and a byte marked last sends the held
// window, up to max(MAX_PATTERN, MAX_REPLACEMENT) results; the queue absorbs
// the difference. A final byte with nothing to send gives one result with
// byte_valid low and out_last high. Each accepted byte passes the command queue,
// the current-command register and the output register before its first result
// appears. Configuration (index 0..3: pattern bytes, pattern length, replacement
// bytes, replacement length) must be written only while the block is idle; the
// block does not enforce this. A pattern length write empties the match window.
module stream_find_and_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          out_last
);
  import sfr_pkg::*;

  localparam int BURST = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CMD_W = 1 + $clog2(BURST + 1) + 8 * BURST;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic [CMD_W-1:0] push_cmd;
  logic [CMD_W-1:0] pop_cmd;

  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .CMD_W           (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sfr_queue #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  sfr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .CMD_W           (CMD_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last)
  );

endmodule

### rtl/sfr_front.sv
module sfr_front #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
  parameter int CMD_W           = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [CMD_W-1:0]            q_cmd
);
  import sfr_pkg::*;

  localparam int BURST  = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CNT_W  = $clog2(BURST + 1);
  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  typedef struct packed {
    logic                 last;
    logic [CNT_W-1:0]     count;
    logic [8*BURST-1:0]   bytes;
  } cmd_t;

  logic [8*MAX_PATTERN-1:0]     pattern;
  logic [LEN_W-1:0]             plen;
  logic [8*MAX_REPLACEMENT-1:0] repl;
  logic [LEN_W-1:0]             rlen;

  logic [8*MAX_PATTERN-1:0] win;
  logic [8*MAX_PATTERN-1:0] win_next;
  logic [FILL_W-1:0]        fill;
  logic [FILL_W-1:0]        fill_next;

  logic [8*MAX_PATTERN-1:0] win_new;
  logic [FILL_W-1:0]        fill_inc;
  logic                     full;
  logic                     hit;
  logic                     accept;
  logic                     push_n;
  cmd_t                     cmd;
  logic [LEN_W-1:0]         len_clamp_p;
  logic [LEN_W-1:0]         len_clamp_r;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && push_n;
  assign q_cmd    = cmd;

  assign len_clamp_p = (cfg_data[LEN_W-1:0] > LEN_W'(MAX_PATTERN)) ?
                       LEN_W'(MAX_PATTERN) : cfg_data[LEN_W-1:0];
  assign len_clamp_r = (cfg_data[LEN_W-1:0] > LEN_W'(MAX_REPLACEMENT)) ?
                       LEN_W'(MAX_REPLACEMENT) : cfg_data[LEN_W-1:0];

  always_comb begin
    win_new = win;
    hit     = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FILL_W'(i) == fill) begin
        win_new[8*i +: 8] = in_byte;
      end
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < plen && win_new[8*i +: 8] != pattern[8*i +: 8]) begin
        hit = 1'b0;
      end
    end
    fill_inc = fill + 1'b1;
    full     = (LEN_W'(fill_inc) == plen);

    cmd.last  = in_last;
    cmd.count = '0;
    cmd.bytes = (8*BURST)'(win_new);
    push_n    = 1'b0;
    win_next  = win_new;
    fill_next = fill_inc;

    if (plen == '0) begin
      cmd.count = CNT_W'(1);
      cmd.bytes = (8*BURST)'(in_byte);
      push_n    = 1'b1;
      win_next  = win;
      fill_next = '0;
    end else if (full && hit) begin
      cmd.count = CNT_W'(rlen);
      cmd.bytes = (8*BURST)'(repl);
      push_n    = in_last || (rlen != '0);
      fill_next = '0;
    end else if (full) begin
      // oldest byte goes out; on the final byte the whole window goes out
      cmd.count = in_last ? CNT_W'(plen) : CNT_W'(1);
      push_n    = 1'b1;
      win_next  = win_new >> 8;
      fill_next = in_last ? '0 : fill;
    end else begin
      cmd.count = in_last ? CNT_W'(fill_inc) : '0;
      push_n    = in_last;
      fill_next = in_last ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      plen    <= '0;
      repl    <= '0;
      rlen    <= '0;
      fill    <= '0;
    end else begin
      if (accept) begin
        fill <= fill_next;
      end
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PATTERN_BYTES:      pattern <= cfg_data[8*MAX_PATTERN-1:0];
          REG_PATTERN_LENGTH: begin
            plen <= len_clamp_p;
            fill <= '0;
          end
          REG_REPLACEMENT_BYTES:  repl <= cfg_data[8*MAX_REPLACEMENT-1:0];
          REG_REPLACEMENT_LENGTH: rlen <= len_clamp_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

endmodule

### rtl/sfr_queue.sv
module sfr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/sfr_back.sv
module sfr_back #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
  parameter int CMD_W           = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  logic [CMD_W-1:0] q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             out_last
);

  localparam int BURST = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CNT_W = $clog2(BURST + 1);
  localparam int IDX_W = (BURST > 1) ? $clog2(BURST) : 1;

  typedef struct packed {
    logic                 last;
    logic [CNT_W-1:0]     count;
    logic [8*BURST-1:0]   bytes;
  } cmd_t;

  cmd_t             cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic             out_ready;
  logic             emit;
  logic             done;
  logic             cur_load;
  logic [7:0]       sel_byte;

  assign out_ready = !out_valid || !out_stall;
  assign emit      = cur_valid && out_ready;
  // a zero-count command is a bare end marker: one result, then done
  assign done      = (cur.count == '0) || (CNT_W'(idx) + 1'b1 == cur.count);
  assign cur_load  = !cur_valid || (emit && done);
  assign q_pop     = cur_load && !q_empty;
  assign sel_byte  = cur.bytes[8*idx +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_load) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= cmd_t'(q_cmd);
    end
    if (emit) begin
      out_byte   <= (cur.count == '0) ? 8'h00 : sel_byte;
      byte_valid <= (cur.count != '0);
      out_last   <= cur.last && done;
    end
  end

endmodule

### rtl/sfr_checker.sv
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       out_last
);

  // a stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
                               $stable(byte_valid) && $stable(out_last))
    else $error("output payload changed while stalled");

  // a bare end marker only ever closes a string
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_last)
    else $error("bare end marker without out_last");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'h00)
    else $error("bare end marker carries a nonzero byte");

  // coming out of reset both sides are empty
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);
